/* sv/acpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and constants
// Payload structs, command and order codes, and the sequencer states used by
// the accumulator CPU execute unit.
// ----------------------------------------------------------------------------
package acpu_pkg;

    localparam int MemWords = 4096;
    localparam int AddrW    = 12;
    localparam int WordW    = 32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ORD_STOP  = 4'd0,
        ORD_LOAD  = 4'd1,
        ORD_STA   = 4'd2,
        ORD_RET   = 4'd3,
        ORD_INPUT = 4'd4,
        ORD_DIV   = 4'd5,
        ORD_MULLO = 4'd6,
        ORD_MULFR = 4'd7,
        ORD_PRINT = 4'd8,
        ORD_AND   = 4'd9,
        ORD_JMP   = 4'd10,
        ORD_JNEG  = 4'd11,
        ORD_HOLD  = 4'd12,
        ORD_CLR   = 4'd13,
        ORD_ADD   = 4'd14,
        ORD_SUB   = 4'd15
    } t_order;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FWAIT,
        ST_OPND,
        ST_OWAIT,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam logic [31:0] AddrField = 32'h0000_3ffc;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] load_address;
        logic [31:0] load_data;
        logic [31:0] typed_word;
    } t_in;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [31:0] accumulator;
        logic [3:0]  order_done;
        logic        print_valid;
        logic [5:0]  print_code;
        logic        took_input;
        logic        stop_seen;
        logic        divide_by_zero;
    } t_out;

endpackage

/* sv/accumulator_cpu_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit: single-accumulator CPU execute unit
// Takes write, start and step requests against a 4096-word memory and
// answers each with the machine state after it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  input   | in        | i_valid / o_ready    | i_data  (acpu_pkg::t_in)
//  result  | out       | o_valid / i_ready    | o_data  (acpu_pkg::t_out)
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (start track)
//
// One request at a time: a write, start or unused request goes straight to the
// result, a step passes fetch, operand read and execute, and the store orders
// add a memory write. Multiply adds a shift-add loop, divide restoring division.
// A result that is not taken holds the sequencer and stalls the next request.
// Reset is synchronous, active low, and clears counter, accumulator,
// start track and control; memory is undefined until written.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit #(
    parameter int MEMORY_WORDS = acpu_pkg::MemWords
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  acpu_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output acpu_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [5:0]     i_cfg_data
);
    import acpu_pkg::*;

    localparam int AW = $clog2(MEMORY_WORDS);

    // Main memory: one port, registered read.
    logic [31:0] r_mem [MEMORY_WORDS];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    t_state      r_state, n_state;
    t_in         r_req, n_req;
    logic [11:0] r_pc, n_pc;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_track, n_track;
    logic [31:0] r_word, n_word;   // instruction, then operand
    logic [3:0]  r_order, n_order;
    logic [11:0] r_addr, n_addr;
    // Serial multiply/divide: r_hi:r_lo is the working pair, r_m the multiplicand
    // or divisor, r_cnt the bit counter.
    logic [32:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_m, n_m;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_ovalid, n_ovalid;
    t_out        r_out, n_out;

    logic [32:0] add_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_acc    <= '0;
            r_track  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_acc    <= n_acc;
            r_track  <= n_track;
            r_ovalid <= n_ovalid;
        end
        r_req   <= n_req;
        r_word  <= n_word;
        r_order <= n_order;
        r_addr  <= n_addr;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_m     <= n_m;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_track  = r_track;
        n_word   = r_word;
        n_order  = r_order;
        n_addr   = r_addr;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_m      = r_m;
        n_cnt    = r_cnt;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        mem_we   = 1'b0;
        mem_addr = r_pc[AW-1:0];
        mem_wdata = r_word;
        add_try  = r_hi + {1'b0, r_m};

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg_valid && o_cfg_ready) begin
            n_track = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_req   = i_data;
                    n_order = ORD_STOP;
                    case (t_cmd'(i_data.cmd))
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = i_data.load_address[AW-1:0];
                            mem_wdata = i_data.load_data;
                            n_state   = ST_OUT;
                        end
                        CMD_START: begin
                            n_pc    = {r_track, 6'd0};
                            n_state = ST_OUT;
                        end
                        CMD_STEP: n_state = ST_FETCH;
                        default:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_FETCH: n_state = ST_FWAIT;
            ST_FWAIT: begin
                n_order = r_rdata[19:16];
                n_addr  = r_rdata[13:2];
                n_state = ST_OPND;
            end
            ST_OPND: begin
                mem_addr = r_addr[AW-1:0];
                n_pc     = r_pc + 12'd1;
                n_state  = ST_OWAIT;
            end
            ST_OWAIT: begin
                mem_addr = r_addr[AW-1:0];
                n_word   = r_rdata;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                case (t_order'(r_order))
                    ORD_LOAD:  n_acc = r_word;
                    ORD_STA: begin
                        n_word  = (r_word & ~AddrField) | (r_acc & AddrField);
                        n_state = ST_WRITE;
                    end
                    ORD_RET: begin
                        n_word  = (r_word & ~AddrField) | {18'd0, r_pc + 12'd1, 2'd0};
                        n_state = ST_WRITE;
                    end
                    ORD_INPUT: n_acc = r_req.typed_word;
                    ORD_DIV: begin
                        if (r_word == '0) begin
                            n_acc = '1;
                        end else begin
                            // Dividend acc<<31 as 64 bits, shifted in serially.
                            n_hi    = '0;
                            n_lo    = r_acc;
                            n_m     = r_word;
                            n_cnt   = 6'd0;
                            n_state = ST_DIV;
                        end
                    end
                    ORD_MULLO, ORD_MULFR: begin
                        n_hi    = '0;
                        n_lo    = r_word;
                        n_m     = r_acc;
                        n_cnt   = 6'd0;
                        n_state = ST_MUL;
                    end
                    ORD_AND: n_acc = r_acc & r_word;
                    ORD_JMP: n_pc = r_addr;
                    ORD_JNEG: begin
                        if (r_acc[31]) begin
                            n_pc = r_addr;
                        end
                    end
                    ORD_HOLD, ORD_CLR: begin
                        n_word  = r_acc & 32'hffff_fffe;
                        n_state = ST_WRITE;
                        if (t_order'(r_order) == ORD_CLR) begin
                            n_acc = '0;
                        end
                    end
                    ORD_ADD: n_acc = r_acc + r_word;
                    ORD_SUB: n_acc = r_acc + (r_word ^ 32'hffff_fffe) + 32'd2;
                    default: ;
                endcase
            end
            ST_MUL: begin
                // Shift-add: one multiplier bit per cycle, product in r_hi:r_lo.
                if (r_lo[0]) begin
                    {n_hi, n_lo} = {1'b0, add_try, r_lo[31:1]};
                end else begin
                    {n_hi, n_lo} = {1'b0, r_hi, r_lo[31:1]};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_acc   = (t_order'(r_order) == ORD_MULLO) ? n_lo : {n_hi[30:0], n_lo[31]};
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                // Restoring divide over 63 dividend bits: acc followed by 31 zeros.
                // Upper bits of the quotient drop out, keeping the low 32.
                n_hi  = {r_hi[31:0], r_lo[31]};
                n_lo  = {r_lo[30:0], 1'b0};
                if (n_hi >= {1'b0, r_m}) begin
                    n_hi  = n_hi - {1'b0, r_m};
                    n_acc = {r_acc[30:0], 1'b1};
                end else begin
                    n_acc = {r_acc[30:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd62) begin
                    n_state = ST_OUT;
                end
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_addr  = r_addr[AW-1:0];
                mem_wdata = r_word;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_out.program_counter = r_pc;
                    n_out.accumulator     = r_acc;
                    n_out.order_done      = '0;
                    n_out.print_valid     = 1'b0;
                    n_out.print_code      = '0;
                    n_out.took_input      = 1'b0;
                    n_out.stop_seen       = 1'b0;
                    n_out.divide_by_zero  = 1'b0;
                    if (t_cmd'(r_req.cmd) == CMD_STEP) begin
                        n_out.order_done     = r_order;
                        n_out.print_valid    = (t_order'(r_order) == ORD_PRINT);
                        n_out.print_code     = (t_order'(r_order) == ORD_PRINT) ?
                                               r_addr[11:6] : 6'd0;
                        n_out.took_input     = (t_order'(r_order) == ORD_INPUT);
                        n_out.stop_seen      = (t_order'(r_order) == ORD_STOP);
                        n_out.divide_by_zero = (t_order'(r_order) == ORD_DIV) &&
                                               (r_word == '0);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // A request is never taken while the sequencer is busy with another.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("request accepted while busy");
    // Every accepted request reaches the result register before the next.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_ovalid || i_ready)) |=> (o_valid && r_state == ST_IDLE))
        else $error("result not posted");
    // The multiply loop stays within its 32 bit steps.
    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt < 6'd32))
        else $error("multiply counter overrun");
`endif

endmodule
